// File: rtl/ggc_pkg.sv
// Shared constants and controller/datapath interface types for the greedy graph colorer.
// Used by ggc_ctrl, ggc_dp and greedy_graph_coloring; depends on nothing else.
package ggc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int NBR_W            = 64;
    localparam int IDX_W            = 6;
    localparam int COLOR_W          = 7;
    localparam int GROUP_W          = 3;
    localparam int GROUP_SIZE       = 8;
    localparam int OUT_TDATA_W      = 24;

    typedef struct packed {
        logic load;
        logic scan;
        logic search;
        logic commit;
    } ggc_cmd_t;

    typedef struct packed {
        logic skip_scan;
        logic scan_last;
        logic found;
    } ggc_status_t;

endpackage

// File: rtl/ggc_ctrl.sv
// Sequencer for the greedy graph colorer: handshakes and the scan/search/commit steps.
// Depends on ggc_pkg for the command and status types.
module ggc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ggc_pkg::ggc_status_t status,
    output ggc_pkg::ggc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb begin
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.search = (state_reg == ST_SEARCH);
        cmd.commit = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.skip_scan ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (status.found) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (cmd.commit) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// File: rtl/ggc_dp.sv
// Datapath of the greedy graph colorer: color store, taken-color scan, first-fit search.
// Depends on ggc_pkg; driven by commands from ggc_ctrl.
module ggc_dp #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ggc_pkg::ggc_cmd_t             cmd,
    input  logic [ggc_pkg::NBR_W-1:0]     neighbors,
    input  logic                          last_vertex,
    output ggc_pkg::ggc_status_t          status,
    output logic [ggc_pkg::IDX_W-1:0]     vertex_index,
    output logic [ggc_pkg::COLOR_W-1:0]   vertex_color,
    output logic [ggc_pkg::COLOR_W-1:0]   colors_used,
    output logic                          overflow_error,
    output logic                          last_out
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = ggc_pkg::COLOR_W;

    logic [CW-1:0] color_mem [MAX_VERTICES];

    logic [CW-1:0]                 counter_reg, counter_next;
    logic [CW-1:0]                 max_color_reg, max_color_next;
    logic [ggc_pkg::NBR_W-1:0]     mask_reg;
    logic                          last_reg;
    logic [AW-1:0]                 scan_reg, scan_next;
    logic                          rd_v_reg, rd_v_next;
    logic [CW-1:0]                 rd_data_reg;
    logic [ggc_pkg::NBR_W-1:0]     taken_reg, taken_next;
    logic [ggc_pkg::GROUP_W-1:0]   group_reg, group_next;
    logic [CW-1:0]                 color_reg, color_next;

    logic [ggc_pkg::IDX_W-1:0]     vertex_index_reg;
    logic [CW-1:0]                 vertex_color_reg;
    logic [CW-1:0]                 colors_used_reg;
    logic                          overflow_error_reg;
    logic                          last_out_reg;

    logic                          overflow;
    logic [AW-1:0]                 idx;
    logic [ggc_pkg::IDX_W-1:0]     scan_bit;
    logic [ggc_pkg::IDX_W-1:0]     taken_bit;
    logic [ggc_pkg::GROUP_SIZE-1:0] grp_free;
    logic [ggc_pkg::GROUP_W-1:0]   grp_pos;
    logic [CW-1:0]                 search_color;
    logic [CW-1:0]                 new_max;

    assign overflow  = (counter_reg >= CW'(MAX_VERTICES));
    assign idx       = counter_reg[AW-1:0];
    assign scan_bit  = ggc_pkg::IDX_W'(scan_reg);
    assign taken_bit = ggc_pkg::IDX_W'(rd_data_reg - CW'(1));
    assign new_max   = (color_reg > max_color_reg) ? color_reg : max_color_reg;

    // Color 64 is always available, so the top bit of the last group counts as free.
    always_comb begin
        grp_free = ~taken_reg[{group_reg, 3'b000} +: ggc_pkg::GROUP_SIZE];
        if (group_reg == '1) begin
            grp_free[ggc_pkg::GROUP_SIZE-1] = 1'b1;
        end
        grp_pos = '0;
        for (int i = ggc_pkg::GROUP_SIZE - 1; i >= 0; i--) begin
            if (grp_free[i]) begin
                grp_pos = ggc_pkg::GROUP_W'(i);
            end
        end
    end

    assign search_color = CW'({group_reg, grp_pos}) + CW'(1);

    always_comb begin
        status.skip_scan = overflow || (counter_reg == '0);
        status.scan_last = ((CW'(scan_reg) + CW'(1)) == counter_reg);
        status.found     = |grp_free;
    end

    always_comb begin
        scan_next      = scan_reg;
        rd_v_next      = cmd.scan && mask_reg[scan_bit];
        taken_next     = taken_reg;
        group_next     = group_reg;
        color_next     = color_reg;
        counter_next   = counter_reg;
        max_color_next = max_color_reg;

        if (rd_v_reg && (rd_data_reg != '0) && (rd_data_reg <= CW'(ggc_pkg::NBR_W))) begin
            taken_next[taken_bit] = 1'b1;
        end
        if (cmd.load) begin
            scan_next  = '0;
            taken_next = '0;
            group_next = '0;
            color_next = overflow ? CW'(0) : CW'(1);
        end
        if (cmd.scan) begin
            scan_next = scan_reg + AW'(1);
        end
        if (cmd.search) begin
            if (status.found) begin
                color_next = search_color;
            end else begin
                group_next = group_reg + ggc_pkg::GROUP_W'(1);
            end
        end
        if (cmd.commit) begin
            if (!overflow) begin
                counter_next   = counter_reg + CW'(1);
                max_color_next = new_max;
            end
            if (last_reg) begin
                counter_next   = '0;
                max_color_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg   <= '0;
            max_color_reg <= '0;
            rd_v_reg      <= 1'b0;
        end else begin
            counter_reg   <= counter_next;
            max_color_reg <= max_color_next;
            rd_v_reg      <= rd_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg  <= scan_next;
        taken_reg <= taken_next;
        group_reg <= group_next;
        color_reg <= color_next;
        if (cmd.load) begin
            mask_reg <= neighbors;
            last_reg <= last_vertex;
        end
        if (cmd.commit) begin
            vertex_index_reg   <= overflow ? '0 : ggc_pkg::IDX_W'(idx);
            vertex_color_reg   <= color_reg;
            colors_used_reg    <= overflow ? max_color_reg : new_max;
            overflow_error_reg <= overflow;
            last_out_reg       <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            rd_data_reg <= color_mem[scan_reg];
        end
        if (cmd.commit && !overflow) begin
            color_mem[idx] <= color_reg;
        end
    end

    assign vertex_index   = vertex_index_reg;
    assign vertex_color   = vertex_color_reg;
    assign colors_used    = colors_used_reg;
    assign overflow_error = overflow_error_reg;
    assign last_out       = last_out_reg;

`ifndef NO_ASSERTIONS
    a_counter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        counter_reg <= CW'(MAX_VERTICES))
        else $error("vertex counter ran past capacity");

    a_max_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        max_color_reg <= counter_reg)
        else $error("more colors in use than vertices colored");

    a_first_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !overflow) |-> ((color_reg != '0) &&
                                       (color_reg <= max_color_reg + CW'(1))))
        else $error("committed color skips an unused color");

    a_no_read_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search |-> !rd_v_reg)
        else $error("store read still in flight during color search");
`endif

endmodule

// File: rtl/greedy_graph_coloring.sv
// First-fit greedy graph colorer: top level joining the sequencer and the datapath.
// Usage:
// The s_ channel takes one adjacency row per vertex, in vertex order: s_tdata is the
// 64-bit neighbor mask and s_tlast marks the final vertex of a graph. The m_ channel
// returns one result per row: vertex index, color (1-based) and running color count in
// m_tdata, the capacity overflow flag in m_tuser and the end-of-graph mark in m_tlast.
// A row for vertex k (k >= 1) walks the stored colors of vertices 0..k-1, one store read
// per cycle, then searches the taken-color set eight colors per cycle. The time between
// accepts grows with k; vertex 0 and rows past capacity skip the walk and the search.
// The result is registered in an output register when the row's work ends. The walk over
// the color store, one read per earlier vertex, sets the rate.
// The output register lets a new row be accepted while the last result waits;
// when m_tready stays low, the next row finishes and then waits until the output frees.
// Reset clears the vertex counter and the color count; the color store needs no
// clearing because only entries written in the current graph are read.
// A row with s_tlast set resets the graph state after its result is produced.
module greedy_graph_coloring #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ggc_pkg::NBR_W-1:0]           s_tdata,  // neighbors[63:0]
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // vertex_index[5:0], vertex_color[12:6], colors_used[19:13], zero fill[23:20]
    output logic [ggc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser,  // overflow_error
    output logic                                m_tlast
);

    ggc_pkg::ggc_cmd_t                cmd;
    ggc_pkg::ggc_status_t             status;
    logic [ggc_pkg::IDX_W-1:0]        vertex_index;
    logic [ggc_pkg::COLOR_W-1:0]      vertex_color;
    logic [ggc_pkg::COLOR_W-1:0]      colors_used;

    ggc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ggc_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .neighbors      (s_tdata),
        .last_vertex    (s_tlast),
        .status         (status),
        .vertex_index   (vertex_index),
        .vertex_color   (vertex_color),
        .colors_used    (colors_used),
        .overflow_error (m_tuser),
        .last_out       (m_tlast)
    );

    assign m_tdata = {4'b0000, colors_used, vertex_color, vertex_index};

endmodule
